// File: src/esc_pkg.sv
// Package for the escape sequence decoder: phase codes, character constants,
// result and push record types, and small decode helpers. No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_OCT   = 3'd2,
        PH_HEX   = 3'd3,
        PH_DROP  = 3'd4
    } t_phase;

    // Characters the decoder reacts to
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_SEVEN  = 8'h37;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_LO_A   = 8'h61;
    localparam logic [7:0] C_LO_F   = 8'h66;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_F   = 8'h46;
    localparam logic [7:0] C_X      = 8'h78;
    localparam logic [7:0] C_B      = 8'h62;
    localparam logic [7:0] C_F      = 8'h66;
    localparam logic [7:0] C_N      = 8'h6E;
    localparam logic [7:0] C_R      = 8'h72;
    localparam logic [7:0] C_T      = 8'h74;

    // Control codes produced by the letter escapes
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;
    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_HT = 8'h09;

    // Result queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       out_last;
    } t_res;

    // Results produced by one accepted byte, at most two
    typedef struct packed {
        logic [1:0] n;
        t_res       res0;
        t_res       res1;
    } t_push;

    // Build a result; the byte reads as zero when it is not valid
    function automatic t_res mk_res(input logic [7:0] b, input logic valid,
                                    input logic err, input logic last);
        t_res r;
        r.out_byte     = valid ? b : 8'h00;
        r.byte_valid   = valid;
        r.decode_error = err;
        r.out_last     = last;
        return r;
    endfunction

    // Hex digit value, either case; bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_nib(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= C_ZERO && b <= C_NINE) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= C_LO_A && b <= C_LO_F) || (b >= C_UP_A && b <= C_UP_F)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// File: src/esc_ifs.sv
// Valid/ready channel interfaces for the escape sequence decoder:
// one for string bytes in, one for decoded results out. No dependencies.
`timescale 1ns / 1ps

interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       out_last;

    modport source (output valid, output out_byte, output byte_valid,
                    output decode_error, output out_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input decode_error, input out_last, output ready);
endinterface

// File: src/esc_decode.sv
// Escape decoder core: phase, digit count and accumulator registers plus the
// per-byte decision logic. Uses esc_pkg and the esc_in_if channel.
`timescale 1ns / 1ps

module esc_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_room,
    esc_in_if.sink         i_in,
    output esc_pkg::t_push o_push
);
    import esc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [1:0] r_dcnt, n_dcnt;
    logic [7:0] r_acc, n_acc;

    logic       take;
    logic [7:0] b;
    logic       last;
    logic [4:0] hv;
    logic       is_oct;
    logic       plain_has;
    logic       plain_esc;
    t_res       plain_res;
    logic [7:0] oct_acc;
    logic [7:0] code;
    t_push      push;

    assign i_in.ready = i_room;
    assign take       = i_in.valid && i_room;
    assign b          = i_in.in_byte;
    assign last       = i_in.in_last;
    assign hv         = hex_nib(b);
    assign is_oct     = b inside {[C_ZERO:C_SEVEN]};
    assign oct_acc    = {r_acc[4:0], b[2:0]};

    // Plain-text handling of the byte, independent of phase
    always_comb begin
        plain_has = 1'b1;
        plain_esc = 1'b0;
        plain_res = mk_res(b, 1'b1, 1'b0, last);
        if (b == C_BSLASH) begin
            if (last) begin
                plain_res = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
                plain_has = 1'b0;
                plain_esc = 1'b1;
            end
        end
    end

    // Letter escapes map to control codes, anything else stays literal
    always_comb begin
        case (b)
            C_B:     code = CODE_BS;
            C_F:     code = CODE_FF;
            C_N:     code = CODE_LF;
            C_R:     code = CODE_CR;
            C_T:     code = CODE_HT;
            default: code = b;
        endcase
    end

    // Next state and results for the byte on the input channel
    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_acc   = r_acc;
        push    = '0;
        case (r_phase)
            PH_ESC: begin
                if (is_oct) begin
                    n_acc   = {5'd0, b[2:0]};
                    n_dcnt  = 2'd1;
                    n_phase = PH_OCT;
                    if (last) begin
                        push.n    = 2'd1;
                        push.res0 = mk_res({5'd0, b[2:0]}, 1'b1, 1'b0, 1'b1);
                    end
                end else if (b == C_X) begin
                    n_acc   = 8'h00;
                    n_dcnt  = 2'd0;
                    n_phase = PH_HEX;
                    if (last) begin
                        push.n    = 2'd1;
                        push.res0 = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                    end
                end else begin
                    n_phase   = PH_PLAIN;
                    push.n    = 2'd1;
                    push.res0 = mk_res(code, 1'b1, 1'b0, last);
                end
            end
            PH_OCT: begin
                if (is_oct) begin
                    n_acc  = oct_acc;
                    n_dcnt = 2'(r_dcnt + 2'd1);
                    if (r_dcnt == 2'd2 || last) begin
                        push.n    = 2'd1;
                        push.res0 = mk_res(oct_acc, 1'b1, 1'b0, last);
                        n_phase   = PH_PLAIN;
                    end
                end else begin
                    // Flush the pending value, then treat the byte as text
                    push.res0 = mk_res(r_acc, 1'b1, 1'b0, 1'b0);
                    push.res1 = plain_res;
                    push.n    = plain_has ? 2'd2 : 2'd1;
                    n_phase   = plain_esc ? PH_ESC : PH_PLAIN;
                end
            end
            PH_HEX: begin
                if (!hv[4]) begin
                    n_phase = PH_DROP;
                    if (last) begin
                        push.n    = 2'd1;
                        push.res0 = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                    end
                end else if (r_dcnt == 2'd0) begin
                    n_acc  = {4'd0, hv[3:0]};
                    n_dcnt = 2'd1;
                    if (last) begin
                        push.n    = 2'd1;
                        push.res0 = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                    end
                end else begin
                    n_phase   = PH_PLAIN;
                    push.n    = 2'd1;
                    push.res0 = mk_res({r_acc[3:0], hv[3:0]}, 1'b1, 1'b0, last);
                end
            end
            PH_DROP: begin
                if (last) begin
                    push.n    = 2'd1;
                    push.res0 = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                end
            end
            default: begin
                push.res0 = plain_res;
                push.n    = plain_has ? 2'd1 : 2'd0;
                n_phase   = plain_esc ? PH_ESC : PH_PLAIN;
            end
        endcase
        // The final byte of a string always restarts decoding
        if (last || n_phase == PH_PLAIN) begin
            n_phase = PH_PLAIN;
            n_dcnt  = 2'd0;
            n_acc   = 8'h00;
        end
        if (!take) begin
            push = '0;
        end
    end

    assign o_push = push;

    // Advance decoder state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_dcnt  <= 2'd0;
            r_acc   <= 8'h00;
        end else if (take) begin
            r_phase <= n_phase;
            r_dcnt  <= n_dcnt;
            r_acc   <= n_acc;
        end
    end

    // A final byte leaves the decoder in plain text
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && last |=> r_phase == PH_PLAIN)
        else $error("decoder did not restart after final byte");

    // A final byte yields exactly one result marked last, in the last slot
    a_last_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && last |-> (push.n == 2'd1 && push.res0.out_last) ||
                         (push.n == 2'd2 && push.res1.out_last && !push.res0.out_last))
        else $error("final byte without a single last result");

    // The first of two results is always a flushed octal value
    a_pair_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n == 2'd2 |-> r_phase == PH_OCT && push.res0.byte_valid &&
                           !push.res0.decode_error)
        else $error("unexpected two-result transfer");

    // An error result never carries a byte
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd0 && push.res0.decode_error |->
            !push.res0.byte_valid && push.res0.out_last)
        else $error("error result carries a byte");

endmodule

// File: src/esc_outq.sv
// Result queue: takes up to two results per cycle and hands out one per
// transfer from a registered entry. Uses esc_pkg and the esc_out_if channel.
`timescale 1ns / 1ps

module esc_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  esc_pkg::t_push i_push,
    output logic           o_room,
    esc_out_if.source      o_out
);
    import esc_pkg::*;

    t_res             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             pop;
    logic [QAW-1:0]   wp1;
    t_res             head;

    assign pop    = o_out.valid && o_out.ready;
    assign wp1    = QAW'(r_wp + 1'b1);
    assign o_room = r_cnt <= (QAW+1)'(QDEPTH - 2);

    // Pointer and fill updates
    always_comb begin
        n_wp  = QAW'(r_wp + QAW'(i_push.n));
        n_rp  = pop ? QAW'(r_rp + 1'b1) : r_rp;
        n_cnt = (QAW+1)'(r_cnt + (QAW+1)'(i_push.n) - (QAW+1)'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_q[r_wp] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            r_q[wp1] <= i_push.res1;
        end
    end

    // Present the oldest result
    assign head               = r_q[r_rp];
    assign o_out.valid        = r_cnt != '0;
    assign o_out.out_byte     = head.out_byte;
    assign o_out.byte_valid   = head.byte_valid;
    assign o_out.decode_error = head.decode_error;
    assign o_out.out_last     = head.out_last;

endmodule

// File: src/escape_sequence_decoder.sv
// Results are stored in a four-entry queue and offered from a registered entry.
// Throughput: one byte per cycle while input ready holds; a byte that ends an
// octal run early can give two results, which leave one per output transfer.
// Input ready holds while the queue has room for two results.
// Reset (synchronous, active low) returns to plain text and empties the queue.
`timescale 1ns / 1ps

module escape_sequence_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esc_in_if.sink    i_in,
    esc_out_if.source o_out
);
    import esc_pkg::*;

    t_push push;
    logic  room;

    // Decode one byte per transfer
    esc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_room  (room),
        .i_in    (i_in),
        .o_push  (push)
    );

    // Queue results toward the output channel
    esc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
